>>> hdl/tslm_pkg.sv
`timescale 1ns / 1ps
package tslm_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;

	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_SYN = 2'd1;
	localparam logic [1:0] KIND_FIN = 2'd2;
	localparam logic [1:0] KIND_RST = 2'd3;

	typedef struct packed {
		logic        func;
		logic        header_ok;
		logic [31:0] peer_addr;
		logic [15:0] ip_total_length;
		logic [3:0]  ip_header_words;
		logic [3:0]  tcp_header_words;
		logic [31:0] seq_number;
		logic [31:0] ack_number;
		logic [3:0]  tcp_flags;
		logic [63:0] timestamp_ns;
	} in_t;

	typedef struct packed {
		logic        event_valid;
		logic [1:0]  event_kind;
		logic [31:0] event_seq;
		logic [31:0] event_ack;
		logic [63:0] event_value;
		logic        table_full_drop;
		logic [63:0] latency_sum;
		logic [63:0] latency_count;
		logic [63:0] bytes_sent_total;
		logic [63:0] bytes_received_total;
	} out_t;

	// Carried from cell to cell along the table.
	typedef struct packed {
		logic        any_hit;
		logic        any_free;
		logic [63:0] hit_time;
	} chain_t;

	// Broadcast from the control to every cell.
	typedef struct packed {
		logic        lookup;
		logic        store;
		logic        use_free;
		logic        clear;
		logic [31:0] key;
		logic [63:0] send_time;
	} cmd_t;

endpackage

>>> hdl/tcp_seq_ack_latency_matcher.sv
`timescale 1ns / 1ps
// Matches outbound TCP segments against inbound ACKs and reports round-trip
// latency plus SYN/FIN/RST lifecycle events, one result per packet summary.
// Each request goes through register, decode and payload length, a
// parallel key compare in every table cell, then a commit pass along the
// chain of cells that finds the hit, the lowest free cell and the stored send
// time. A new request is taken when the previous one has committed; a result
// waiting on the output does not block the next request until its commit.
// The send table holds TABLE_ENTRIES records; zero target_addr matches every peer.
// target_addr must be written over cfg only while the block is idle (not enforced).
module tcp_seq_ack_latency_matcher #(
	parameter int TABLE_ENTRIES = tslm_pkg::TABLE_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  tslm_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output tslm_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [31:0]    cfg_data
);
	import tslm_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_LOOK, ST_COMMIT} state_t;
	typedef enum logic [1:0] {OP_NONE, OP_LIFE, OP_SEND, OP_RECV} op_t;

	state_t      state_q;
	logic        out_valid_q;
	logic [31:0] target_q;
	logic [63:0] lat_sum_q;
	logic [63:0] lat_cnt_q;
	logic [63:0] sent_q;
	logic [63:0] recv_q;

	in_t         item_s1;
	op_t         op_s2;
	logic [1:0]  kind_s2;
	logic        ackf_s2;
	logic [15:0] payload_s2;
	logic [31:0] key_s2;
	logic [31:0] seq_s2;
	logic [31:0] ack_s2;
	logic [63:0] ts_s2;
	out_t        out_q;

	logic        accept;
	logic        can_out;
	logic        commit;
	logic        match;
	logic [6:0]  hdr_len;
	logic [15:0] payload;
	op_t         op_d;
	logic [1:0]  kind_d;
	logic [63:0] latency;
	logic        ack_hit;
	cmd_t        cmd;
	chain_t      chain [TABLE_ENTRIES+1];

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign can_out   = !out_valid_q || !out_stall;
	assign commit    = (state_q == ST_COMMIT) && can_out;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// Decode
	always_comb begin
		match   = item_s1.header_ok &&
			((target_q == 32'd0) || (item_s1.peer_addr == target_q));
		hdr_len = {1'b0, item_s1.ip_header_words, 2'b00} +
			{1'b0, item_s1.tcp_header_words, 2'b00};
		payload = (item_s1.ip_total_length >= {9'd0, hdr_len}) ?
			(item_s1.ip_total_length - {9'd0, hdr_len}) : 16'd0;
		kind_d  = item_s1.tcp_flags[0] ? KIND_SYN :
			(item_s1.tcp_flags[1] ? KIND_FIN : KIND_RST);
		if (!match) begin
			op_d = OP_NONE;
		end else if (|item_s1.tcp_flags[2:0]) begin
			op_d = OP_LIFE;
		end else if (!item_s1.func) begin
			op_d = (payload != 16'd0) ? OP_SEND : OP_NONE;
		end else begin
			op_d = OP_RECV;
		end
	end

	assign latency = ts_s2 - chain[TABLE_ENTRIES].hit_time;
	assign ack_hit = (op_s2 == OP_RECV) && ackf_s2 && chain[TABLE_ENTRIES].any_hit;

	always_comb begin
		cmd.lookup    = (state_q == ST_LOOK);
		cmd.store     = commit && (op_s2 == OP_SEND);
		cmd.use_free  = !chain[TABLE_ENTRIES].any_hit;
		cmd.clear     = commit && (op_s2 == OP_RECV) && ackf_s2;
		cmd.key       = key_s2;
		cmd.send_time = ts_s2;
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		tslm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.chain_in (chain[i]),
			.chain_out(chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			target_q    <= 32'd0;
			lat_sum_q   <= 64'd0;
			lat_cnt_q   <= 64'd0;
			sent_q      <= 64'd0;
			recv_q      <= 64'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				target_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					if (can_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
				if (op_s2 == OP_SEND) begin
					sent_q <= sent_q + {48'd0, payload_s2};
				end
				if (op_s2 == OP_RECV) begin
					recv_q <= recv_q + {48'd0, payload_s2};
				end
				if (ack_hit) begin
					lat_sum_q <= lat_sum_q + latency;
					lat_cnt_q <= lat_cnt_q + 64'd1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if (state_q == ST_CALC) begin
			op_s2      <= op_d;
			kind_s2    <= kind_d;
			ackf_s2    <= item_s1.tcp_flags[3];
			payload_s2 <= payload;
			key_s2     <= item_s1.func ? item_s1.ack_number :
				(item_s1.seq_number + {16'd0, payload});
			seq_s2     <= item_s1.seq_number;
			ack_s2     <= item_s1.ack_number;
			ts_s2      <= item_s1.timestamp_ns;
		end
		if (commit) begin
			out_q.event_valid          <= (op_s2 == OP_LIFE) || ack_hit;
			out_q.event_kind           <= (op_s2 == OP_LIFE) ? kind_s2 : KIND_ACK;
			out_q.event_seq            <= (op_s2 == OP_LIFE) ? seq_s2 :
				(ack_hit ? ack_s2 : 32'd0);
			out_q.event_ack            <= ((op_s2 == OP_LIFE) || ack_hit) ? ack_s2 : 32'd0;
			out_q.event_value          <= (op_s2 == OP_LIFE) ? ts_s2 :
				(ack_hit ? latency : 64'd0);
			out_q.table_full_drop      <= (op_s2 == OP_SEND) &&
				!chain[TABLE_ENTRIES].any_hit && !chain[TABLE_ENTRIES].any_free;
			out_q.latency_sum          <= ack_hit ? (lat_sum_q + latency) : lat_sum_q;
			out_q.latency_count        <= ack_hit ? (lat_cnt_q + 64'd1) : lat_cnt_q;
			out_q.bytes_sent_total     <= (op_s2 == OP_SEND) ?
				(sent_q + {48'd0, payload_s2}) : sent_q;
			out_q.bytes_received_total <= (op_s2 == OP_RECV) ?
				(recv_q + {48'd0, payload_s2}) : recv_q;
		end
	end

	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CALC))
		else $error("accepted request did not enter decode");

	a_commit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) && !can_out |=> (state_q == ST_COMMIT) && out_valid_q)
		else $error("commit left while output still full");

	a_look_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |=> (state_q == ST_COMMIT))
		else $error("lookup not followed by commit");

	a_out_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("commit produced no result");

endmodule

>>> hdl/tslm_cell.sv
`timescale 1ns / 1ps
module tslm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  tslm_pkg::cmd_t   cmd,
	input  tslm_pkg::chain_t chain_in,
	output tslm_pkg::chain_t chain_out
);
	import tslm_pkg::*;

	logic        valid_q;
	logic        hit_q;
	logic [31:0] key_q;
	logic [63:0] time_q;
	logic        free;
	logic        claim;

	assign free  = !valid_q;
	// Lowest free cell: no free cell below this one.
	assign claim = free && !chain_in.any_free;

	assign chain_out.any_hit  = chain_in.any_hit || hit_q;
	assign chain_out.any_free = chain_in.any_free || free;
	assign chain_out.hit_time = chain_in.hit_time | (hit_q ? time_q : 64'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.lookup) begin
				hit_q <= valid_q && (key_q == cmd.key);
			end
			if (cmd.store && (hit_q || (cmd.use_free && claim))) begin
				valid_q <= 1'b1;
			end else if (cmd.clear && hit_q) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && (hit_q || (cmd.use_free && claim))) begin
			key_q  <= cmd.key;
			time_q <= cmd.send_time;
		end
	end

endmodule
